### hw/rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int CP_W  = 31;
  localparam int LEN_W = 3;
  localparam int OUT_W = 40;

  localparam logic [CP_W-1:0] MIN_LEN2 = 31'h0000080;
  localparam logic [CP_W-1:0] MIN_LEN3 = 31'h0000800;
  localparam logic [CP_W-1:0] MIN_LEN4 = 31'h0010000;
  localparam logic [CP_W-1:0] MIN_LEN5 = 31'h0200000;
  localparam logic [CP_W-1:0] MIN_LEN6 = 31'h4000000;

  typedef struct packed {
    logic [LEN_W-1:0] remaining;
    logic [CP_W-1:0]  acc;
    logic [LEN_W-1:0] total;
  } utf8d_state_t;

  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             decode_error;
  } utf8d_result_t;

  function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
    case (len)
      3'd2:    min_value = MIN_LEN2;
      3'd3:    min_value = MIN_LEN3;
      3'd4:    min_value = MIN_LEN4;
      3'd5:    min_value = MIN_LEN5;
      3'd6:    min_value = MIN_LEN6;
      default: min_value = '0;
    endcase
  endfunction

endpackage

### hw/rtl/utf8_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Byte-serial decoder for original UTF-8 (sequences of 1 to 6 bytes).
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one raw text byte per word. m_* carries one word per decoded
//   sequence or error: code point and length in m_tdata, error flag in
//   m_tuser. Lead and middle bytes of a sequence produce no output word.
//   An error word (overlong form, bad lead byte, broken continuation) has
//   zero code point and zero length; the offending byte is dropped and the
//   decoder returns to idle.
//   Timing: an input register and an output register surround the decode
//   logic; a result word is loaded into the output register when the step
//   that consumes its last byte from the input register advances.
//   Throughput is one byte per cycle unless the output stalls, as the decode step is combinational.
//   Stall: when m_tready is low the output word holds; the input register
//   still fills, then s_tready drops until the output drains.
//   Reset: rst (synchronous) empties both registers and returns the decoder
//   to idle with a cleared accumulator.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core
  import utf8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [30:0] code_point, [33:31] seq_length, zero fill
  output logic             m_tuser    // [0] decode_error
);

  logic          in_valid;
  logic [7:0]    in_byte;
  utf8d_state_t  st;
  utf8d_state_t  st_next;
  utf8d_result_t res;
  logic          advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  utf8d_step u_step (
    .st      (st),
    .in_byte (in_byte),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {{(OUT_W - CP_W - LEN_W){1'b0}}, res.seq_length, res.code_point};
      m_tuser <= res.decode_error;
    end
  end

endmodule

### hw/rtl/utf8d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_step
// One decode step: current sequence state and one byte in, next state and an
// optional result out.
// ----------------------------------------------------------------------------
module utf8d_step
  import utf8d_pkg::*;
(
  input  utf8d_state_t  st,
  input  logic [7:0]    in_byte,
  output utf8d_state_t  st_next,
  output utf8d_result_t res
);

  logic [CP_W-1:0]  acc_shift;
  logic [LEN_W-1:0] rem_dec;

  assign acc_shift = {st.acc[CP_W-7:0], in_byte[5:0]};
  assign rem_dec   = st.remaining - 3'd1;

  always_comb begin
    st_next = st;
    res     = '0;
    if (st.remaining == '0) begin
      if (!in_byte[7]) begin
        res.valid      = 1'b1;
        res.code_point = {23'd0, in_byte};
        res.seq_length = 3'd1;
      end else if (in_byte[7:6] == 2'b10 || in_byte[7:1] == 7'h7f) begin
        res.valid        = 1'b1;
        res.decode_error = 1'b1;
      end else if (!in_byte[5]) begin
        st_next.acc = {26'd0, in_byte[4:0]};
        st_next.total = 3'd2;
        st_next.remaining = 3'd1;
      end else if (!in_byte[4]) begin
        st_next.acc = {27'd0, in_byte[3:0]};
        st_next.total = 3'd3;
        st_next.remaining = 3'd2;
      end else if (!in_byte[3]) begin
        st_next.acc = {28'd0, in_byte[2:0]};
        st_next.total = 3'd4;
        st_next.remaining = 3'd3;
      end else if (!in_byte[2]) begin
        st_next.acc = {29'd0, in_byte[1:0]};
        st_next.total = 3'd5;
        st_next.remaining = 3'd4;
      end else begin
        st_next.acc = {30'd0, in_byte[0]};
        st_next.total = 3'd6;
        st_next.remaining = 3'd5;
      end
    end else if (in_byte[7:6] != 2'b10) begin
      st_next          = '0;
      res.valid        = 1'b1;
      res.decode_error = 1'b1;
    end else if (rem_dec != '0) begin
      st_next.acc       = acc_shift;
      st_next.remaining = rem_dec;
    end else begin
      st_next   = '0;
      res.valid = 1'b1;
      if (st.total < 3'd2 || st.total > 3'd6 || acc_shift < min_value(st.total)) begin
        res.decode_error = 1'b1;
      end else begin
        res.code_point = acc_shift;
        res.seq_length = st.total;
      end
    end
  end

endmodule
